>>> rtl/core/forward_max_match_segmenter_top_macros.svh
// assertion helpers for the segmenter
`ifndef FORWARD_MAX_MATCH_SEGMENTER_TOP_MACROS_SVH
`define FORWARD_MAX_MATCH_SEGMENTER_TOP_MACROS_SVH

// concurrent implication checked on every rising clock edge outside reset
`define FMMS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// property that checks nxt in the cycle after cond
`define FMMS_ASSERT_NEXT(lbl, cond, nxt, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (nxt)) else $error(msg);

`endif

>>> rtl/core/fmms_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package fmms_pkg;
  localparam int MAX_LEN      = 8;
  localparam int DICT_ENTRIES = 1024;
  localparam int CODE_W       = 21;
  localparam int LEN_W        = $clog2(MAX_LEN + 2);
  localparam int SLOT_W       = $clog2(MAX_LEN);
  localparam int ENT_W        = $clog2(DICT_ENTRIES + 1);
  localparam int EIDX_W       = $clog2(DICT_ENTRIES);
  localparam int CADDR_W      = $clog2(DICT_ENTRIES * MAX_LEN);

  // dictionary write port
  typedef struct packed {
    logic               char_we;
    logic [CADDR_W-1:0] char_addr;
    logic [CODE_W-1:0]  char_data;
    logic               len_we;
    logic [EIDX_W-1:0]  len_addr;
    logic [LEN_W-1:0]   len_data;
  } dict_wr_t;
endpackage
`default_nettype wire

>>> rtl/core/fmms_dict.sv
`timescale 1ns / 1ps
`default_nettype none
module fmms_dict (
  input  wire logic                       clk,
  input  wire fmms_pkg::dict_wr_t         wr,
  input  wire logic [fmms_pkg::CADDR_W-1:0] char_raddr,
  input  wire logic [fmms_pkg::EIDX_W-1:0]  len_raddr,
  output logic      [fmms_pkg::CODE_W-1:0]  char_rdata,
  output logic      [fmms_pkg::LEN_W-1:0]   len_rdata
);
  logic [fmms_pkg::CODE_W-1:0] char_mem [fmms_pkg::DICT_ENTRIES * fmms_pkg::MAX_LEN];
  logic [fmms_pkg::LEN_W-1:0]  len_mem  [fmms_pkg::DICT_ENTRIES];

  // word characters, one slot row per entry
  always_ff @(posedge clk) begin
    if (wr.char_we) begin
      char_mem[wr.char_addr] <= wr.char_data;
    end
    char_rdata <= char_mem[char_raddr];
  end

  // word lengths
  always_ff @(posedge clk) begin
    if (wr.len_we) begin
      len_mem[wr.len_addr] <= wr.len_data;
    end
    len_rdata <= len_mem[len_raddr];
  end
endmodule
`default_nettype wire

>>> rtl/core/forward_max_match_segmenter_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Forward maximum matching segmenter. An item is taken when start is high and busy is low;
// mode 0 items load dictionary characters (last ends a word) and keep the block idle; mode 1
// items are text characters. Once the window holds as many characters as the longest
// stored word, or at end of text, the block scans every stored entry through the
// dictionary memories, each character compare being a read state then a check state. A
// segmentation step has a set-up state, then a read and a check for the first compare of
// each stored entry and for each further compare after a matching character (none while
// the dictionary is empty or only one character waits), and then
// puts out one character per cycle on out_code with strobe high. The receiver cannot
// stall: each result is valid for exactly one cycle. No clearing pass is needed after reset.
module forward_max_match_segmenter_top (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic                        mode,
  input  wire logic [fmms_pkg::CODE_W-1:0] char_code,
  input  wire logic                        last,
  output logic                             strobe,
  output logic      [fmms_pkg::CODE_W-1:0] out_code,
  output logic                             word_end,
  output logic                             text_end
);
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_START = 3'd1;
  localparam logic [2:0] ST_RD    = 3'd2;
  localparam logic [2:0] ST_CHK   = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;

  localparam logic [fmms_pkg::LEN_W-1:0] MAXL = fmms_pkg::LEN_W'(fmms_pkg::MAX_LEN);
  localparam logic [fmms_pkg::ENT_W-1:0] FULL = fmms_pkg::ENT_W'(fmms_pkg::DICT_ENTRIES);
  localparam logic [fmms_pkg::LEN_W-1:0] ONE  = fmms_pkg::LEN_W'(1);

  logic [2:0]                    state;
  logic [fmms_pkg::ENT_W-1:0]    entry_count;
  logic [fmms_pkg::LEN_W-1:0]    longest_length;
  logic [fmms_pkg::LEN_W-1:0]    load_position;
  logic [fmms_pkg::CODE_W-1:0]   window_chars [fmms_pkg::MAX_LEN];
  logic [fmms_pkg::LEN_W-1:0]    window_count;
  logic                          final_text;
  logic [fmms_pkg::ENT_W-1:0]    entry;     // entry under scan
  logic [fmms_pkg::SLOT_W-1:0]   slot;      // character under compare
  logic [fmms_pkg::LEN_W-1:0]    best;      // best match, then characters left to emit

  fmms_pkg::dict_wr_t            wr;
  logic [fmms_pkg::CADDR_W-1:0]  char_raddr;
  logic [fmms_pkg::CODE_W-1:0]   char_rdata;
  logic [fmms_pkg::LEN_W-1:0]    len_rdata;

  logic                          accept;
  logic [fmms_pkg::LEN_W-1:0]    pos_inc;
  logic                          store_ok;
  logic [fmms_pkg::LEN_W-1:0]    win_w;
  logic [fmms_pkg::LEN_W-1:0]    wc_after;
  logic                          skip;
  logic                          full_match;
  logic                          last_entry;

  assign accept = start && !busy;
  assign busy   = (state != ST_IDLE);

  // load side: position saturates one past the longest legal word
  assign pos_inc  = (load_position <= MAXL) ? load_position + ONE : load_position;
  assign store_ok = (entry_count < FULL);

  always_comb begin
    wr.char_we   = accept && !mode && (load_position < MAXL) && store_ok;
    wr.char_addr = fmms_pkg::CADDR_W'(entry_count[fmms_pkg::EIDX_W-1:0]
                   * fmms_pkg::CADDR_W'(fmms_pkg::MAX_LEN)
                   + fmms_pkg::CADDR_W'(load_position[fmms_pkg::SLOT_W-1:0]));
    wr.char_data = char_code;
    wr.len_we    = accept && !mode && last && (pos_inc <= MAXL) && store_ok;
    wr.len_addr  = entry_count[fmms_pkg::EIDX_W-1:0];
    wr.len_data  = pos_inc;
  end

  // scan read address follows entry and slot; data arrives in the check cycle
  assign char_raddr = fmms_pkg::CADDR_W'(entry[fmms_pkg::EIDX_W-1:0]
                      * fmms_pkg::CADDR_W'(fmms_pkg::MAX_LEN)
                      + fmms_pkg::CADDR_W'(slot));

  fmms_dict u_dict (
    .clk        (clk),
    .wr         (wr),
    .char_raddr (char_raddr),
    .len_raddr  (entry[fmms_pkg::EIDX_W-1:0]),
    .char_rdata (char_rdata),
    .len_rdata  (len_rdata)
  );

  // window length to wait for, one while the dictionary is empty
  assign win_w    = (longest_length == '0) ? ONE : longest_length;
  assign wc_after = (window_count < MAXL) ? window_count + ONE : window_count;

  // an entry is dropped once it cannot beat the best match, is longer than the window, or a character differs
  assign skip       = (len_rdata <= best) || (len_rdata > window_count)
                      || (char_rdata != window_chars[slot]);
  assign full_match = (fmms_pkg::LEN_W'(slot) + ONE == len_rdata);
  assign last_entry = (entry + fmms_pkg::ENT_W'(1) == entry_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      entry_count    <= '0;
      longest_length <= '0;
      load_position  <= '0;
      window_count   <= '0;
      final_text     <= 1'b0;
      entry          <= '0;
      slot           <= '0;
      best           <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept && !mode) begin
            if (last) begin
              if (wr.len_we) begin
                entry_count <= entry_count + fmms_pkg::ENT_W'(1);
                if (pos_inc > longest_length) begin
                  longest_length <= pos_inc;
                end
              end
              load_position <= '0;
            end else begin
              load_position <= pos_inc;
            end
          end else if (accept) begin
            if (window_count < MAXL) begin
              window_chars[window_count[fmms_pkg::SLOT_W-1:0]] <= char_code;
            end
            window_count <= wc_after;
            final_text   <= last;
            if (last || (wc_after >= win_w)) begin
              state <= ST_START;
            end
          end
        end
        ST_START: begin
          best  <= ONE;
          entry <= '0;
          slot  <= '0;
          if (window_count <= ONE || entry_count == '0) begin
            state <= ST_EMIT;
          end else begin
            state <= ST_RD;
          end
        end
        ST_RD: begin
          state <= ST_CHK;
        end
        ST_CHK: begin
          if (skip || full_match) begin
            if (!skip) begin
              best <= len_rdata;
            end
            slot  <= '0;
            entry <= entry + fmms_pkg::ENT_W'(1);
            state <= last_entry ? ST_EMIT : ST_RD;
          end else begin
            slot  <= slot + fmms_pkg::SLOT_W'(1);
            state <= ST_RD;
          end
        end
        ST_EMIT: begin
          // head goes out, window slides by one
          for (int k = 0; k < fmms_pkg::MAX_LEN - 1; k++) begin
            window_chars[k] <= window_chars[k+1];
          end
          window_count <= window_count - ONE;
          best         <= best - ONE;
          if (best == ONE) begin
            state <= (final_text && window_count > ONE) ? ST_START : ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign strobe   = (state == ST_EMIT);
  assign out_code = window_chars[0];
  assign word_end = strobe && (best == ONE);
  assign text_end = word_end && final_text && (window_count == ONE);

`include "forward_max_match_segmenter_top_macros.svh"

  // window never sits full between items
  `FMMS_ASSERT(a_win_room, !busy |-> (window_count < MAXL), "window full while idle")
  // scan never runs past the stored entries
  `FMMS_ASSERT(a_scan_range, (state == ST_CHK) |-> (entry < entry_count), "scan beyond entries")
  // end of text ends the run
  `FMMS_ASSERT_NEXT(a_text_done, text_end, !busy && window_count == '0, "text end not idle")
  // a result always has a character behind it
  `FMMS_ASSERT(a_emit_src, strobe |-> (window_count != '0 && best != '0), "emit from empty window")
endmodule
`default_nettype wire

>>> bench/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import fmms_pkg::*;

  localparam int WDOG_LIMIT = 200000;  // idle cycles allowed with no item taken and no output character
  localparam int RAND_ITEMS = 240;
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_TEXT = 1'b1;

  typedef struct packed {
    logic              mode;
    logic [CODE_W-1:0] code;
    logic              last;
  } seg_item_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              wend;
    logic              tend;
  } seg_res_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              mode = 1'b0;
  logic [CODE_W-1:0] char_code = '0;
  logic              last = 1'b0;
  logic              busy;
  logic              strobe;
  logic [CODE_W-1:0] out_code;
  logic              word_end;
  logic              text_end;

  forward_max_match_segmenter_top DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .mode(mode), .char_code(char_code), .last(last),
    .strobe(strobe), .out_code(out_code), .word_end(word_end), .text_end(text_end)
  );

  always #1 clk = ~clk;

  // pending items and predicted output characters
  seg_item_t pend_q[$];
  seg_res_t  seg_exp_q[$];
  int        n_err = 0;
  int        n_items = 0;
  int        n_chars = 0;

  // shadow copy of the dictionary and text window
  logic [CODE_W-1:0] dict_ch [DICT_ENTRIES][MAX_LEN];
  int                dict_len [DICT_ENTRIES];
  int                n_words = 0;
  int                longest = 0;
  int                load_pos = 0;
  logic [CODE_W-1:0] win [MAX_LEN];
  int                win_cnt = 0;

  // longest stored word matching the window head, else 1
  function automatic int head_len(int avail);
    int i;
    for (int len = avail; len >= 2; len--) begin
      for (int e = 0; e < n_words; e++) begin
        if (dict_len[e] != len) continue;
        for (i = 0; i < len; i++) if (dict_ch[e][i] != win[i]) break;
        if (i == len) return len;
      end
    end
    return 1;
  endfunction

  // take one word off the window head and queue its characters
  task automatic emit_word(bit fin);
    int avail;
    int n;
    seg_res_t r;
    avail = (win_cnt > MAX_LEN) ? MAX_LEN : win_cnt;
    n = (avail <= 1) ? avail : head_len(avail);
    for (int i = 0; i < n; i++) begin
      r.code = win[i];
      r.wend = (i + 1 == n);
      r.tend = (i + 1 == n) && fin && (n == avail);
      seg_exp_q.insert(seg_exp_q.size(), r);
    end
    for (int i = n; i < avail; i++) win[i - n] = win[i];
    win_cnt = avail - n;
  endtask

  task automatic predict_item(seg_item_t it);
    int w;
    int k;
    if (it.mode == MODE_LOAD) begin
      if (load_pos < MAX_LEN && n_words < DICT_ENTRIES) dict_ch[n_words][load_pos] = it.code;
      if (load_pos <= MAX_LEN) load_pos++;
      if (it.last) begin
        if (load_pos <= MAX_LEN && n_words < DICT_ENTRIES) begin
          dict_len[n_words] = load_pos;
          n_words++;
          if (load_pos > longest) longest = load_pos;
        end
        load_pos = 0;
      end
    end else begin
      w = (longest == 0) ? 1 : longest;
      if (w > MAX_LEN) w = MAX_LEN;
      if (win_cnt < MAX_LEN) begin
        win[win_cnt] = it.code;
        win_cnt++;
      end
      if (it.last) begin
        k = seg_exp_q.size();
        while (win_cnt > 0 && seg_exp_q.size() - k < MAX_LEN) emit_word(1'b1);
        win_cnt = 0;
      end else if (win_cnt >= w) begin
        emit_word(1'b0);
      end
    end
  endtask

  // driver: one item per handshake, random gaps except near the end
  seg_item_t drv_item;
  int        gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      gap = 0;
    end else if (start && busy) begin
      // hold the item until the block takes it
    end else begin
      if (start) begin
        predict_item(drv_item);
        n_items++;
      end
      if (gap > 0) begin
        gap--;
        start <= 1'b0;
      end else if (pend_q.size() > 0) begin
        drv_item = pend_q.pop_front();
        mode <= drv_item.mode;
        char_code <= drv_item.code;
        last <= drv_item.last;
        start <= 1'b1;
        if (pend_q.size() > 40 && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 10);
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: each strobed character against the oldest prediction
  always @(posedge clk) begin : mon
    seg_res_t e;
    if (!rst && strobe) begin
      n_chars++;
      if (seg_exp_q.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("unexpected output char %h", out_code);
      end else begin
        e = seg_exp_q.pop_front();
        if (out_code !== e.code || word_end !== e.wend || text_end !== e.tend) begin
          n_err++;
          if (n_err <= 10)
            $display("mismatch: exp code %h we %b te %b, got code %h we %b te %b",
                     e.code, e.wend, e.tend, out_code, word_end, text_end);
        end
      end
    end
  end

  // watchdog on cycles with no item or output character taken
  int idle_cyc = 0;
  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) idle_cyc <= 0;
    else idle_cyc <= idle_cyc + 1;
    if (idle_cyc >= WDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic put(logic m, logic [CODE_W-1:0] c, logic l);
    seg_item_t it;
    it.mode = m;
    it.code = c;
    it.last = l;
    pend_q.insert(pend_q.size(), it);
  endtask

  logic [CODE_W-1:0] alpha [4];

  initial begin : stim
    int cnt;
    int len;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // empty dictionary: window of one, single char text, two char text
    put(MODE_TEXT, 21'h1FFFFF, 1'b1);
    put(MODE_TEXT, 21'h000000, 1'b0);
    put(MODE_TEXT, 21'h0A5A5A, 1'b1);
    // eight character word of extreme codes, then a too long word
    for (int i = 0; i < MAX_LEN; i++) put(MODE_LOAD, (i % 2) ? 21'h1FFFFF : 21'h0, i == MAX_LEN - 1);
    for (int i = 0; i <= MAX_LEN; i++) put(MODE_LOAD, 21'h155555, i == MAX_LEN);
    // one character word, never changes the outcome
    put(MODE_LOAD, 21'h000000, 1'b1);
    // text matching the long word, then one spare char ending the text
    for (int i = 0; i < MAX_LEN; i++) put(MODE_TEXT, (i % 2) ? 21'h1FFFFF : 21'h0, 1'b0);
    put(MODE_TEXT, 21'h1FFFFF, 1'b1);
    // word loaded while text sits in the window
    put(MODE_TEXT, 21'h000001, 1'b0);
    put(MODE_LOAD, 21'h000001, 1'b0);
    put(MODE_LOAD, 21'h000002, 1'b1);
    put(MODE_TEXT, 21'h000002, 1'b1);

    alpha[0] = 21'h0;
    alpha[1] = 21'h1FFFFF;
    alpha[2] = CODE_W'($urandom_range(0, 21'h1FFFFF));
    alpha[3] = CODE_W'($urandom_range(0, 21'h1FFFFF));
    cnt = 0;
    while (cnt < RAND_ITEMS) begin
      if ($urandom_range(0, 9) < 3 && n_words < 60) begin
        // dictionary word, now and then too long
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(MAX_LEN + 1, MAX_LEN + 3)
                                           : $urandom_range(1, MAX_LEN);
        for (int i = 0; i < len; i++) put(MODE_LOAD, alpha[$urandom_range(0, 3)], i == len - 1);
        cnt += len;
      end else begin
        // text run, mostly from the dictionary alphabet, with some noise chars
        len = $urandom_range(1, 14);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 6) == 0)
            put(MODE_TEXT, CODE_W'($urandom_range(0, 21'h1FFFFF)), i == len - 1);
          else
            put(MODE_TEXT, alpha[$urandom_range(0, 2)], i == len - 1);
          if ($urandom_range(0, 19) == 0) put(MODE_LOAD, alpha[$urandom_range(0, 3)], 1'b1);
        end
        cnt += len;
      end
      if ($urandom_range(0, 15) == 0) alpha[3] = CODE_W'($urandom_range(0, 21'h1FFFFF));
    end

    wait (pend_q.size() == 0 && !start);
    @(posedge clk);
    wait (seg_exp_q.size() == 0 && !busy);
    repeat (100) @(posedge clk);
    $display("items taken %0d, output chars checked %0d, dictionary words %0d",
             n_items, n_chars, n_words);
    $display("mismatches %0d, left over predictions %0d", n_err, seg_exp_q.size());
    if (n_err == 0 && seg_exp_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
